@@ sv/anb_pkg.sv @@
package anb_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 23;
    localparam int unsigned TYPE_W   = 6;
    localparam int unsigned AVCC_W   = 24;
    localparam int unsigned HIST_W   = 3 * BYTE_W;
    localparam int unsigned CODEC_W  = 2;
    localparam int unsigned M_DATA_W = 88;

    // bytes kept per unit before the rest is dropped
    localparam logic [POS_W-1:0] MAX_UNIT_BYTES = POS_W'(4194304);

    localparam logic [AVCC_W-1:0] AVCC_MAX = '1;
    localparam logic [BYTE_W-1:0] START_BYTE = BYTE_W'(1);
    localparam logic [1:0] HIST_FULL = 2'd3;
    localparam logic [1:0] HIST_PAIR = 2'd2;

    // codec register codes
    localparam logic [CODEC_W-1:0] CODEC_AVC  = 2'd0;
    localparam logic [CODEC_W-1:0] CODEC_HEVC = 2'd1;

    // header types
    localparam logic [4:0] AVC_TYPE_MASK = 5'h1F;
    localparam logic [TYPE_W-1:0] HEVC_TYPE_MASK = 6'h3F;
    localparam logic [TYPE_W-1:0] AVC_IDR      = 6'd5;
    localparam logic [TYPE_W-1:0] AVC_SPS      = 6'd7;
    localparam logic [TYPE_W-1:0] AVC_PPS      = 6'd8;
    localparam logic [TYPE_W-1:0] HEVC_IRAP_LO = 6'd16;
    localparam logic [TYPE_W-1:0] HEVC_IRAP_HI = 6'd21;
    localparam logic [TYPE_W-1:0] HEVC_VPS     = 6'd32;
    localparam logic [TYPE_W-1:0] HEVC_SPS     = 6'd33;
    localparam logic [TYPE_W-1:0] HEVC_PPS     = 6'd34;

    typedef enum logic [1:0] {
        PS_NONE = 2'd0,
        PS_VPS  = 2'd1,
        PS_SPS  = 2'd2,
        PS_PPS  = 2'd3
    } ps_kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_NAL   = 2'd1,
        ST_OVERFLOW = 2'd2
    } unit_status_t;

    // scanner view of the current byte
    typedef struct packed {
        logic             scanning;
        logic             det;
        logic             det4;
        logic [POS_W-1:0] pos;
    } scan_t;

    // classification of one nal unit
    typedef struct packed {
        logic [TYPE_W-1:0] nal_hdr_type;
        logic              is_key;
        ps_kind_t          kind;
    } nal_class_t;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [5:0]        pad;
        unit_status_t      unit_status;
        logic [AVCC_W-1:0] unit_avcc_size;
        logic              unit_keyframe;
        ps_kind_t          param_set_kind;
        logic              nal_is_keyframe;
        logic [TYPE_W-1:0] nal_hdr_type;
        logic [POS_W-1:0]  nal_length;
        logic [POS_W-1:0]  nal_offset;
    } rec_t;

endpackage

@@ sv/annexb_nal_splitter_classifier.sv @@
// Annex B start code parser for H.264 / H.265 access units.
// Input stream: one byte per word; s_tdata[7:0] holds the byte, s_tlast marks the
// last byte of the access unit and s_tuser[0] forces the unit keyframe flag.
// Output stream: at most one record per input byte, one record per nal unit found,
// the last record of a unit carries m_tlast and the unit summary (avcc size,
// sticky keyframe, status). A unit with no nal still gives one summary record.
// Codec is chosen through cfg_we / cfg_wdata; the user must write it only while the
// stream is idle, the block does not enforce this. Throughput: one byte per cycle
// while m_tready keeps the result register free; the start code window and
// classifier are a single combinational pass. A byte accepted sits in the input
// register; when it advances its record is written into the result register.
// Reset clears codec select, the unit state and both register stages.
// When m_tready is low the result register holds; the input register keeps one
// byte and s_tready drops until the record is taken, so no word is lost.
module annexb_nal_splitter_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [anb_pkg::CODEC_W-1:0]   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,  // data_byte
    input  logic                          s_tlast,
    input  logic [0:0]                    s_tuser,  // forced_keyframe
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // nal_offset, nal_length, nal_hdr_type, nal_is_keyframe, param_set_kind,
    // unit_keyframe, unit_avcc_size, unit_status, zero fill
    output logic [anb_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast
);
    import anb_pkg::*;

    logic [CODEC_W-1:0] codec_reg;
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               in_last_reg;
    logic               in_force_reg;
    logic               out_free;
    logic               advance;

    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   span_reg, span_next;
    logic               inside_reg, inside_next;
    logic               hdr_pend_reg, hdr_pend_next;
    logic [TYPE_W-1:0]  cur_type_reg, cur_type_next;
    logic               sticky_reg, sticky_next;
    logic [AVCC_W-1:0]  avcc_reg, avcc_next;
    logic               ovf_reg, ovf_next;

    logic               m_valid_reg;
    rec_t               m_data_reg, m_data_next;
    logic               m_last_reg;
    logic               has_out;

    scan_t              scan;
    nal_class_t         cls;
    logic [TYPE_W-1:0]  type_now;
    logic               hdr_take;
    logic               emit_det;
    logic               emit_trail;
    logic               emitted;
    logic [POS_W-1:0]   span_upd;
    logic [POS_W-1:0]   len_det;
    logic [POS_W-1:0]   nal_len;
    logic [AVCC_W:0]    avcc_sum;
    logic [AVCC_W-1:0]  avcc_upd;
    logic               sticky_upd;

    // handshake between the two register stages
    assign out_free = !m_valid_reg || m_tready;
    assign advance = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tlast = m_last_reg;

    anb_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .scan      (scan)
    );

    anb_class u_class (
        .codec    (codec_reg),
        .hdr_take (hdr_take),
        .hdr_byte (in_byte_reg),
        .cur_type (cur_type_reg),
        .len_nz   (nal_len != '0),
        .type_now (type_now),
        .cls      (cls)
    );

    // nal boundaries and lengths
    always_comb begin
        hdr_take = hdr_pend_reg && scan.scanning;
        if (!scan.scanning) span_upd = span_reg;
        else if (scan.det) span_upd = '0;
        else span_upd = span_reg + POS_W'(1);
        len_det = span_reg - (scan.det4 ? POS_W'(3) : POS_W'(2));
        emit_det = scan.det && inside_reg;
        emit_trail = in_last_reg && !emit_det && (inside_reg || scan.det)
            && (span_upd != '0);
        emitted = emit_det || emit_trail;
        if (emit_det) nal_len = len_det;
        else if (emit_trail) nal_len = span_upd;
        else nal_len = '0;
        has_out = emit_det || in_last_reg;
    end

    // running unit summary
    always_comb begin
        avcc_sum = {1'b0, avcc_reg} + (AVCC_W+1)'(nal_len) + (AVCC_W+1)'(4);
        if (!emitted) avcc_upd = avcc_reg;
        else if (avcc_sum[AVCC_W]) avcc_upd = AVCC_MAX;
        else avcc_upd = avcc_sum[AVCC_W-1:0];
        sticky_upd = sticky_reg || in_force_reg || (emitted && cls.is_key);
    end

    // result word
    always_comb begin
        m_data_next = '0;
        if (emitted) begin
            m_data_next.nal_offset = start_reg;
            m_data_next.nal_length = nal_len;
            m_data_next.nal_hdr_type = cls.nal_hdr_type;
            m_data_next.nal_is_keyframe = cls.is_key;
            m_data_next.param_set_kind = cls.kind;
        end
        if (in_last_reg) begin
            m_data_next.unit_keyframe = sticky_upd;
            m_data_next.unit_avcc_size = avcc_upd;
            if (ovf_reg || !scan.scanning) m_data_next.unit_status = ST_OVERFLOW;
            else if (avcc_upd == '0) m_data_next.unit_status = ST_NO_NAL;
            else m_data_next.unit_status = ST_OK;
        end
    end

    // unit state, cleared after the last byte of a unit
    always_comb begin
        if (in_last_reg) begin
            start_next = '0;
            span_next = '0;
            inside_next = 1'b0;
            hdr_pend_next = 1'b0;
            cur_type_next = '0;
            sticky_next = 1'b0;
            avcc_next = '0;
            ovf_next = 1'b0;
        end else begin
            start_next = scan.det ? scan.pos + POS_W'(1) : start_reg;
            span_next = span_upd;
            inside_next = inside_reg || scan.det;
            hdr_pend_next = scan.scanning ? scan.det : hdr_pend_reg;
            cur_type_next = hdr_take ? type_now : cur_type_reg;
            sticky_next = sticky_upd;
            avcc_next = avcc_upd;
            ovf_next = ovf_reg || !scan.scanning;
        end
    end

    // config register and input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_reg <= '0;
            in_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) codec_reg <= cfg_wdata;
            if (s_tready) in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
            in_force_reg <= s_tuser[0];
        end
    end

    // unit state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            span_reg <= '0;
            inside_reg <= 1'b0;
            hdr_pend_reg <= 1'b0;
            cur_type_reg <= '0;
            sticky_reg <= 1'b0;
            avcc_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (advance) begin
            start_reg <= start_next;
            span_reg <= span_next;
            inside_reg <= inside_next;
            hdr_pend_reg <= hdr_pend_next;
            cur_type_reg <= cur_type_next;
            sticky_reg <= sticky_next;
            avcc_reg <= avcc_next;
            ovf_reg <= ovf_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && has_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_out) begin
            m_data_reg <= m_data_next;
            m_last_reg <= in_last_reg;
        end
    end

`ifndef SYNTHESIS
    // an empty nal record carries no classification
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.nal_length == '0) |->
        (m_data_reg.nal_hdr_type == '0 && !m_data_reg.nal_is_keyframe
         && m_data_reg.param_set_kind == PS_NONE))
        else $error("empty nal record with classification");

    // summary fields stay zero except on the last record
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |->
        (!m_data_reg.unit_keyframe && m_data_reg.unit_avcc_size == '0
         && m_data_reg.unit_status == ST_OK))
        else $error("summary on a non-final record");

    // a unit reported ok has counted at least one nal
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg && m_data_reg.unit_status == ST_OK) |->
        (m_data_reg.unit_avcc_size >= AVCC_W'(4)))
        else $error("ok status with empty avcc size");

    // unit state is cleared after the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=>
        (avcc_reg == '0 && !inside_reg && !ovf_reg && !sticky_reg))
        else $error("unit state not cleared after last byte");
`endif

endmodule

@@ sv/anb_scan.sv @@
module anb_scan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        advance,
    input  logic [anb_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        last,
    output anb_pkg::scan_t              scan
);
    import anb_pkg::*;

    logic [HIST_W-1:0] hist_reg, hist_next;
    logic [1:0]        hv_reg, hv_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              scanning;
    logic              det4;
    logic              det3;
    logic              det;

    // start code window over the last three bytes plus this one
    always_comb begin
        scanning = (pos_reg < MAX_UNIT_BYTES);
        det4 = (hv_reg == HIST_FULL) && (hist_reg == '0) && (data_byte == START_BYTE);
        det3 = (hv_reg >= HIST_PAIR) && (hist_reg[2*BYTE_W-1:0] == '0)
            && (data_byte == START_BYTE) && !last;
        det = scanning && (det4 || det3);
        scan.scanning = scanning;
        scan.det = det;
        scan.det4 = det4;
        scan.pos = pos_reg;
    end

    // history and position update
    always_comb begin
        hist_next = hist_reg;
        hv_next = hv_reg;
        pos_next = pos_reg;
        if (last) begin
            hist_next = '0;
            hv_next = '0;
            pos_next = '0;
        end else if (scanning) begin
            hist_next = {hist_reg[2*BYTE_W-1:0], data_byte};
            pos_next = pos_reg + POS_W'(1);
            if (det) begin
                hv_next = '0;
            end else if (hv_reg != HIST_FULL) begin
                hv_next = hv_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            hv_reg <= '0;
            pos_reg <= '0;
        end else if (advance) begin
            hist_reg <= hist_next;
            hv_reg <= hv_next;
            pos_reg <= pos_next;
        end
    end

`ifndef SYNTHESIS
    // a detection needs at least two eligible history bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        det |-> (hv_reg == HIST_PAIR || hv_reg == HIST_FULL))
        else $error("start code detected without enough history");

    // position never runs past the byte limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= MAX_UNIT_BYTES)
        else $error("byte position beyond limit");
`endif

endmodule

@@ sv/anb_class.sv @@
module anb_class (
    input  logic [anb_pkg::CODEC_W-1:0] codec,
    input  logic                        hdr_take,
    input  logic [anb_pkg::BYTE_W-1:0]  hdr_byte,
    input  logic [anb_pkg::TYPE_W-1:0]  cur_type,
    input  logic                        len_nz,
    output logic [anb_pkg::TYPE_W-1:0]  type_now,
    output anb_pkg::nal_class_t         cls
);
    import anb_pkg::*;

    logic [TYPE_W-1:0] hdr_type;
    logic              is_key;
    ps_kind_t          kind;

    // header type from the first payload byte
    always_comb begin
        case (codec)
            CODEC_AVC:  hdr_type = {1'b0, hdr_byte[4:0] & AVC_TYPE_MASK};
            CODEC_HEVC: hdr_type = hdr_byte[TYPE_W:1] & HEVC_TYPE_MASK;
            default:    hdr_type = '0;
        endcase
        type_now = hdr_take ? hdr_type : cur_type;
    end

    // keyframe and parameter set classification
    always_comb begin
        is_key = 1'b0;
        kind = PS_NONE;
        case (codec)
            CODEC_AVC: begin
                is_key = (type_now == AVC_IDR);
                if (type_now == AVC_SPS) kind = PS_SPS;
                else if (type_now == AVC_PPS) kind = PS_PPS;
            end
            CODEC_HEVC: begin
                is_key = (type_now >= HEVC_IRAP_LO) && (type_now <= HEVC_IRAP_HI);
                if (type_now == HEVC_VPS) kind = PS_VPS;
                else if (type_now == HEVC_SPS) kind = PS_SPS;
                else if (type_now == HEVC_PPS) kind = PS_PPS;
            end
            default: begin
                is_key = 1'b0;
                kind = PS_NONE;
            end
        endcase
        // an empty nal carries no classification
        cls.nal_hdr_type = len_nz ? type_now : '0;
        cls.is_key = len_nz && is_key;
        cls.kind = len_nz ? kind : PS_NONE;
    end

endmodule
